// ----- sv/request_fifo_with_cancel_defines.svh -----
// Assertion macros shared by the request queue modules.
`ifndef REQUEST_FIFO_WITH_CANCEL_DEFINES_SVH
`define REQUEST_FIFO_WITH_CANCEL_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define RFC_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define RFC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/rfc_pkg.sv -----
// Types and constants shared by the request queue modules.
package rfc_pkg;

    localparam int OP_W      = 3;
    localparam int IN_CH_W   = 8;
    localparam int IN_TY_W   = 4;
    localparam int OUT_CH_W  = 8;
    localparam int OUT_TY_W  = 4;
    localparam int OUT_CNT_W = 7;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 32;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH        = 3'd0,
        OP_POP         = 3'd1,
        OP_DISPATCH    = 3'd2,
        OP_FINISHED    = 3'd3,
        OP_FLUSH       = 3'd4,
        OP_CANCEL_CHTY = 3'd5,
        OP_CANCEL_TY   = 3'd6
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN_RD,
        ST_SCAN_CHK
    } state_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic scan_start;
        logic scan_read;
        logic scan_check;
        logic scan_finish;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic scan_done;
    } status_t;

endpackage

// ----- sv/rfc_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module rfc_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- sv/rfc_ctrl.sv -----
// Controller state machine sequencing request execution and cancel scans.
`include "request_fifo_with_cancel_defines.svh"

module rfc_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    output logic             m_tvalid,
    input  logic             m_tready,
    input  rfc_pkg::status_t status,
    output rfc_pkg::cmd_t    cmd
);
    import rfc_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = !out_valid_reg || m_tready;
                if (s_tvalid && s_tready) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (status.op == OP_CANCEL_CHTY || status.op == OP_CANCEL_TY) begin
                    cmd.scan_start = 1'b1;
                    state_next     = ST_SCAN_RD;
                end else begin
                    cmd.exec   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN_RD: begin
                if (status.scan_done) begin
                    cmd.scan_finish = 1'b1;
                    state_next      = ST_IDLE;
                end else begin
                    cmd.scan_read = 1'b1;
                    state_next    = ST_SCAN_CHK;
                end
            end
            ST_SCAN_CHK: begin
                cmd.scan_check = 1'b1;
                state_next     = ST_SCAN_RD;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        out_valid_next = out_valid_reg;
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if (cmd.exec || cmd.scan_finish) begin
            out_valid_next = 1'b1;
        end
    end

    assign m_tvalid = out_valid_reg;

    `RFC_ASSERT_NEXT(a_accept_to_exec, s_tvalid && s_tready, state_reg == ST_EXEC, "accepted request did not enter execution")
    `RFC_ASSERT_IMPL(a_check_after_read, state_reg == ST_SCAN_CHK, $past(state_reg) == ST_SCAN_RD, "scan check without a preceding read")
    `RFC_ASSERT_IMPL(a_result_source, $rose(out_valid_reg), $past(state_reg) == ST_EXEC || $past(state_reg) == ST_SCAN_RD, "result raised outside execution or scan end")

endmodule

// ----- sv/rfc_dp.sv -----
// Datapath: queue pointers, busy flag, entry storage, cancel compaction and result registers.
`include "request_fifo_with_cancel_defines.svh"

module rfc_dp #(
    parameter int QUEUE_DEPTH  = 64,
    parameter int CHANNEL_BITS = 8,
    parameter int TYPE_BITS    = 4
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic [rfc_pkg::OP_W-1:0]         s_op,
    input  logic [rfc_pkg::IN_CH_W-1:0]      s_channel,
    input  logic [rfc_pkg::IN_TY_W-1:0]      s_req_type,
    input  rfc_pkg::cmd_t                    cmd,
    output rfc_pkg::status_t                 status,
    output logic                             ok,
    output logic                             overflow,
    output logic [rfc_pkg::OUT_CH_W-1:0]     out_channel,
    output logic [rfc_pkg::OUT_TY_W-1:0]     out_type,
    output logic [rfc_pkg::OUT_CNT_W-1:0]    removed_count,
    output logic [rfc_pkg::OUT_CNT_W-1:0]    occupancy
);
    import rfc_pkg::*;

    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W  = CNT_W + 1;
    localparam int WORD_W = CHANNEL_BITS + TYPE_BITS;

    op_t                     op_reg, op_next;
    logic [CHANNEL_BITS-1:0] ch_reg, ch_next;
    logic [TYPE_BITS-1:0]    ty_reg, ty_next;
    logic [PTR_W-1:0]        head_reg, head_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic                    busy_reg, busy_next;
    logic [CNT_W-1:0]        idx_reg, idx_next;
    logic [CNT_W-1:0]        kept_reg, kept_next;
    logic [CNT_W-1:0]        removed_reg, removed_next;

    logic                    ok_reg, ok_next;
    logic                    ovf_reg, ovf_next;
    logic [OUT_CH_W-1:0]     och_reg, och_next;
    logic [OUT_TY_W-1:0]     oty_reg, oty_next;
    logic [OUT_CNT_W-1:0]    rem_reg, rem_next;
    logic [OUT_CNT_W-1:0]    occ_reg, occ_next;

    logic                    wr_en, rd_en;
    logic [PTR_W-1:0]        wr_addr, rd_addr;
    logic [WORD_W-1:0]       wr_data, rd_data;
    logic [CHANNEL_BITS-1:0] rd_ch;
    logic [TYPE_BITS-1:0]    rd_ty;
    logic                    full, empty, hit;

    function automatic logic [PTR_W-1:0] slot_at(
        input logic [PTR_W-1:0] head,
        input logic [CNT_W-1:0] offset
    );
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(head) + SUM_W'(offset);
        if (sum >= SUM_W'(QUEUE_DEPTH)) begin
            sum = sum - SUM_W'(QUEUE_DEPTH);
        end
        return PTR_W'(sum);
    endfunction

    assign rd_ch = rd_data[WORD_W-1:TYPE_BITS];
    assign rd_ty = rd_data[TYPE_BITS-1:0];
    assign full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign hit   = (rd_ty == ty_reg) && ((op_reg == OP_CANCEL_TY) || (rd_ch == ch_reg));

    assign rd_en   = cmd.capture || cmd.scan_read;
    assign rd_addr = cmd.capture ? head_reg : slot_at(head_reg, idx_reg);
    assign wr_en   = (cmd.exec && (op_reg == OP_PUSH) && !full) || (cmd.scan_check && !hit);
    assign wr_addr = cmd.scan_check ? slot_at(head_reg, kept_reg) : slot_at(head_reg, count_reg);
    assign wr_data = cmd.scan_check ? rd_data : {ch_reg, ty_reg};

    rfc_ram #(
        .WIDTH (WORD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb begin
        op_next      = op_reg;
        ch_next      = ch_reg;
        ty_next      = ty_reg;
        head_next    = head_reg;
        count_next   = count_reg;
        busy_next    = busy_reg;
        idx_next     = idx_reg;
        kept_next    = kept_reg;
        removed_next = removed_reg;
        ok_next      = ok_reg;
        ovf_next     = ovf_reg;
        och_next     = och_reg;
        oty_next     = oty_reg;
        rem_next     = rem_reg;
        occ_next     = occ_reg;

        if (cmd.capture) begin
            op_next = op_t'(s_op);
            ch_next = CHANNEL_BITS'(s_channel);
            ty_next = TYPE_BITS'(s_req_type);
        end

        if (cmd.exec) begin
            ok_next  = 1'b0;
            ovf_next = 1'b0;
            och_next = '0;
            oty_next = '0;
            rem_next = '0;
            case (op_reg)
                OP_PUSH: begin
                    if (full) begin
                        ovf_next = 1'b1;
                    end else begin
                        count_next = count_reg + 1'b1;
                        ok_next    = 1'b1;
                    end
                end
                OP_POP: begin
                    if (!empty) begin
                        head_next  = slot_at(head_reg, CNT_W'(1));
                        count_next = count_reg - 1'b1;
                        ok_next    = 1'b1;
                        och_next   = OUT_CH_W'(rd_ch);
                        oty_next   = OUT_TY_W'(rd_ty);
                    end
                end
                OP_DISPATCH: begin
                    if (!empty && !busy_reg) begin
                        head_next  = slot_at(head_reg, CNT_W'(1));
                        count_next = count_reg - 1'b1;
                        busy_next  = 1'b1;
                        ok_next    = 1'b1;
                        och_next   = OUT_CH_W'(rd_ch);
                        oty_next   = OUT_TY_W'(rd_ty);
                    end
                end
                OP_FINISHED: begin
                    busy_next = 1'b0;
                end
                OP_FLUSH: begin
                    count_next = '0;
                    head_next  = '0;
                    busy_next  = 1'b0;
                end
                default: begin
                end
            endcase
            occ_next = OUT_CNT_W'(count_next);
        end

        if (cmd.scan_start) begin
            idx_next     = '0;
            kept_next    = '0;
            removed_next = '0;
        end

        if (cmd.scan_check) begin
            idx_next = idx_reg + 1'b1;
            if (hit) begin
                removed_next = removed_reg + 1'b1;
            end else begin
                kept_next = kept_reg + 1'b1;
            end
        end

        if (cmd.scan_finish) begin
            count_next = kept_reg;
            busy_next  = 1'b0;
            ok_next    = 1'b0;
            ovf_next   = 1'b0;
            och_next   = '0;
            oty_next   = '0;
            rem_next   = OUT_CNT_W'(removed_reg);
            occ_next   = OUT_CNT_W'(kept_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg    <= '0;
            count_reg   <= '0;
            busy_reg    <= 1'b0;
            idx_reg     <= '0;
            kept_reg    <= '0;
            removed_reg <= '0;
        end else begin
            head_reg    <= head_next;
            count_reg   <= count_next;
            busy_reg    <= busy_next;
            idx_reg     <= idx_next;
            kept_reg    <= kept_next;
            removed_reg <= removed_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg  <= op_next;
        ch_reg  <= ch_next;
        ty_reg  <= ty_next;
        ok_reg  <= ok_next;
        ovf_reg <= ovf_next;
        och_reg <= och_next;
        oty_reg <= oty_next;
        rem_reg <= rem_next;
        occ_reg <= occ_next;
    end

    assign status.op        = op_reg;
    assign status.scan_done = (idx_reg == count_reg);

    assign ok            = ok_reg;
    assign overflow      = ovf_reg;
    assign out_channel   = och_reg;
    assign out_type      = oty_reg;
    assign removed_count = rem_reg;
    assign occupancy     = occ_reg;

    `RFC_ASSERT_IMPL(a_count_bound, 1'b1, count_reg <= CNT_W'(QUEUE_DEPTH), "occupancy exceeds queue depth")
    `RFC_ASSERT_IMPL(a_scan_tally, 1'b1, SUM_W'(kept_reg) + SUM_W'(removed_reg) == SUM_W'(idx_reg), "kept plus removed differs from entries scanned")
    `RFC_ASSERT_IMPL(a_scan_in_range, cmd.scan_check, idx_reg < count_reg, "scan check beyond the last entry")

endmodule

// ----- sv/request_fifo_with_cancel.sv -----
// Top level of the request queue with push, pop, dispatch, flush and selective cancel.
//
// One request enters on the s_ stream (op, channel, request type) and exactly one
// result leaves on the m_ stream for each request, in order.
// Push, pop, dispatch, finished, flush and the unused op code: the request is registered,
// executed in ST_EXEC and its result registered, and a new request can be accepted at
// the edge where that result is taken.
// Both cancels walk the held entries through the single read port of the entry RAM,
// reading and then checking each entry in turn before the result is registered.
// Only one request is in work at a time; s_tready is low while a request executes.
// Reset empties the queue and clears the busy flag; the entry RAM is not cleared, as
// only live entries are ever used.
// When the receiver holds m_tready low, the result stays on m_tdata and no further
// request is accepted until it has been taken.
module request_fifo_with_cancel #(
    parameter int QUEUE_DEPTH  = 64,
    parameter int CHANNEL_BITS = 8,
    parameter int TYPE_BITS    = 4
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // op[2:0], channel[10:3], req_type[14:11], zero[15]
    input  logic [rfc_pkg::S_TDATA_W-1:0]     s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // ok[0], overflow[1], out_channel[9:2], out_type[13:10],
    // removed_count[20:14], occupancy[27:21], zero[31:28]
    output logic [rfc_pkg::M_TDATA_W-1:0]     m_tdata
);
    import rfc_pkg::*;

    cmd_t                 cmd;
    status_t              status;
    logic                 ok, overflow;
    logic [OUT_CH_W-1:0]  out_channel;
    logic [OUT_TY_W-1:0]  out_type;
    logic [OUT_CNT_W-1:0] removed_count, occupancy;

    rfc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    rfc_dp #(
        .QUEUE_DEPTH  (QUEUE_DEPTH),
        .CHANNEL_BITS (CHANNEL_BITS),
        .TYPE_BITS    (TYPE_BITS)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_op          (s_tdata[2:0]),
        .s_channel     (s_tdata[10:3]),
        .s_req_type    (s_tdata[14:11]),
        .cmd           (cmd),
        .status        (status),
        .ok            (ok),
        .overflow      (overflow),
        .out_channel   (out_channel),
        .out_type      (out_type),
        .removed_count (removed_count),
        .occupancy     (occupancy)
    );

    assign m_tdata = {4'b0000, occupancy, removed_count, out_type, out_channel, overflow, ok};

endmodule

// ----- verif/tb_top.sv -----
// Self-checking testbench for the request queue with push, pop, dispatch, flush and cancel.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rfc_pkg::*;

    localparam int          QUEUE_DEPTH     = 64;
    localparam int          ITEM_TARGET     = 1600;
    localparam int          HOLD_OFF_CYCLES = 300;
    localparam int          DRAIN_CYCLES    = 2 * QUEUE_DEPTH + 20;
    localparam int          CYCLE_LIMIT     = 600000;
    localparam logic [2:0]  OP_UNUSED       = 3'd7;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    typedef struct packed {
        logic [3:0]           pad;
        logic [OUT_CNT_W-1:0] occ;
        logic [OUT_CNT_W-1:0] removed;
        logic [OUT_TY_W-1:0]  out_ty;
        logic [OUT_CH_W-1:0]  out_ch;
        logic                 overflow;
        logic                 ok;
    } reply_t;

    typedef struct {
        logic [OP_W-1:0]    op;
        logic [IN_CH_W-1:0] ch;
        logic [IN_TY_W-1:0] ty;
        bit                 typed;
        reply_t             want;
    } plan_row_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    logic [IN_CH_W-1:0] slot_ch [QUEUE_DEPTH];
    logic [IN_TY_W-1:0] slot_ty [QUEUE_DEPTH];
    logic [5:0]         head_slot = '0;
    int unsigned        held      = 0;
    bit                 engaged   = 1'b0;

    reply_t      expected_replies[$];
    plan_row_t   plan[$];
    int unsigned accepted_total  = 0;
    int unsigned mismatches      = 0;
    int unsigned cycle_count     = 0;
    int unsigned send_gap_pct    = 0;
    int unsigned recv_stall_pct  = 0;
    bit          hold_off_wanted = 1'b0;

    request_fifo_with_cancel #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .CHANNEL_BITS(IN_CH_W),
        .TYPE_BITS   (IN_TY_W)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always #5 aclk = ~aclk;

    function automatic reply_t apply_request(logic [OP_W-1:0] op, logic [IN_CH_W-1:0] ch,
                                             logic [IN_TY_W-1:0] ty);
        reply_t      r;
        logic [5:0]  src;
        logic [5:0]  dst;
        int unsigned kept;
        int unsigned idx;
        r = '0;
        case (op)
            OP_PUSH: begin
                if (held == QUEUE_DEPTH) begin
                    r.overflow = 1'b1;
                end else begin
                    dst = head_slot + 6'(held);
                    slot_ch[dst] = ch;
                    slot_ty[dst] = ty;
                    held++;
                    r.ok = 1'b1;
                end
            end
            OP_POP, OP_DISPATCH: begin
                if (held != 0 && !(op == OP_DISPATCH && engaged)) begin
                    r.out_ch = slot_ch[head_slot];
                    r.out_ty = slot_ty[head_slot];
                    head_slot = head_slot + 6'd1;
                    held--;
                    r.ok = 1'b1;
                    if (op == OP_DISPATCH) begin
                        engaged = 1'b1;
                    end
                end
            end
            OP_FINISHED: begin
                engaged = 1'b0;
            end
            OP_FLUSH: begin
                held = 0;
                head_slot = '0;
                engaged = 1'b0;
            end
            OP_CANCEL_CHTY, OP_CANCEL_TY: begin
                kept = 0;
                for (idx = 0; idx < held; idx++) begin
                    src = head_slot + 6'(idx);
                    if (slot_ty[src] == ty && (op == OP_CANCEL_TY || slot_ch[src] == ch)) begin
                        r.removed = r.removed + 1'b1;
                    end else begin
                        dst = head_slot + 6'(kept);
                        slot_ch[dst] = slot_ch[src];
                        slot_ty[dst] = slot_ty[src];
                        kept++;
                    end
                end
                held = kept;
                engaged = 1'b0;
            end
            default: begin
            end
        endcase
        r.occ = OUT_CNT_W'(held);
        return r;
    endfunction

    function automatic plan_row_t plan_row(logic [OP_W-1:0] op, logic [IN_CH_W-1:0] ch,
                                           logic [IN_TY_W-1:0] ty, bit typed, logic ok,
                                           logic ovf, logic [OUT_CH_W-1:0] och,
                                           logic [OUT_TY_W-1:0] oty,
                                           logic [OUT_CNT_W-1:0] rem,
                                           logic [OUT_CNT_W-1:0] occ);
        plan_row_t row;
        row.op    = op;
        row.ch    = ch;
        row.ty    = ty;
        row.typed = typed;
        row.want  = '{pad: 4'h0, occ: occ, removed: rem, out_ty: oty, out_ch: och,
                      overflow: ovf, ok: ok};
        return row;
    endfunction

    function automatic logic [IN_CH_W-1:0] pick_channel();
        return ($urandom_range(99) < 60) ? IN_CH_W'($urandom_range(3))
                                         : IN_CH_W'($urandom_range(255));
    endfunction

    function automatic logic [IN_TY_W-1:0] pick_type();
        return ($urandom_range(99) < 50) ? IN_TY_W'($urandom_range(3))
                                         : IN_TY_W'($urandom_range(15));
    endfunction

    task automatic set_idle_mode(idle_mode_t mode);
        case (mode)
            IDLE_SENDER:   begin send_gap_pct = 55; recv_stall_pct = 0;  end
            IDLE_RECEIVER: begin send_gap_pct = 0;  recv_stall_pct = 55; end
            IDLE_BOTH:     begin send_gap_pct = 14; recv_stall_pct = 14; end
            default:       begin send_gap_pct = 0;  recv_stall_pct = 0;  end
        endcase
    endtask

    task automatic offer_request(logic [OP_W-1:0] op, logic [IN_CH_W-1:0] ch,
                                 logic [IN_TY_W-1:0] ty, bit typed = 1'b0,
                                 reply_t want = '0);
        reply_t predicted;
        while ($urandom_range(99) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, ty, ch, op};
        do @(posedge aclk); while (!s_tready);
        predicted = apply_request(op, ch, ty);
        expected_replies.push_back(typed ? want : predicted);
        accepted_total++;
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        reply_t got;
        reply_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (expected_replies.size() == 0) begin
                $display("%0t: unexpected result, expected none, got 0x%0h", $time, m_tdata);
                mismatches++;
            end else begin
                want = expected_replies.pop_front();
                check_field("ok", 32'(want.ok), 32'(got.ok));
                check_field("overflow", 32'(want.overflow), 32'(got.overflow));
                check_field("out_channel", 32'(want.out_ch), 32'(got.out_ch));
                check_field("out_type", 32'(want.out_ty), 32'(got.out_ty));
                check_field("removed_count", 32'(want.removed), 32'(got.removed));
                check_field("occupancy", 32'(want.occ), 32'(got.occ));
                check_field("padding", 32'(want.pad), 32'(got.pad));
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     expected_replies.size());
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        forever begin
            @(posedge aclk);
            if (hold_off_wanted) begin
                hold_off_wanted = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial begin
        int unsigned        n;
        int unsigned        w;
        logic [OP_W-1:0]    op;
        logic [IN_CH_W-1:0] ch;
        logic [IN_TY_W-1:0] ty;
        logic [5:0]         src;

        plan.push_back(plan_row(OP_POP, 8'h00, 4'h0, 1'b1, 1'b0, 1'b0, 8'h00, 4'h0, 7'd0, 7'd0));
        plan.push_back(plan_row(OP_DISPATCH, 8'h00, 4'h0, 1'b1, 1'b0, 1'b0, 8'h00, 4'h0, 7'd0,
                                7'd0));
        plan.push_back(plan_row(OP_FINISHED, 8'h00, 4'h0, 1'b1, 1'b0, 1'b0, 8'h00, 4'h0, 7'd0,
                                7'd0));
        plan.push_back(plan_row(OP_UNUSED, 8'hff, 4'hf, 1'b1, 1'b0, 1'b0, 8'h00, 4'h0, 7'd0,
                                7'd0));
        plan.push_back(plan_row(OP_CANCEL_TY, 8'h00, 4'hf, 1'b1, 1'b0, 1'b0, 8'h00, 4'h0, 7'd0,
                                7'd0));
        plan.push_back(plan_row(OP_CANCEL_CHTY, 8'hff, 4'hf, 1'b1, 1'b0, 1'b0, 8'h00, 4'h0, 7'd0,
                                7'd0));
        plan.push_back(plan_row(OP_PUSH, 8'hff, 4'hf, 1'b1, 1'b1, 1'b0, 8'h00, 4'h0, 7'd0, 7'd1));
        plan.push_back(plan_row(OP_PUSH, 8'h00, 4'h0, 1'b1, 1'b1, 1'b0, 8'h00, 4'h0, 7'd0, 7'd2));
        plan.push_back(plan_row(OP_PUSH, 8'hff, 4'h0, 1'b1, 1'b1, 1'b0, 8'h00, 4'h0, 7'd0, 7'd3));
        plan.push_back(plan_row(OP_PUSH, 8'h00, 4'hf, 1'b1, 1'b1, 1'b0, 8'h00, 4'h0, 7'd0, 7'd4));
        plan.push_back(plan_row(OP_DISPATCH, 8'h00, 4'h0, 1'b1, 1'b1, 1'b0, 8'hff, 4'hf, 7'd0,
                                7'd3));
        plan.push_back(plan_row(OP_DISPATCH, 8'h00, 4'h0, 1'b1, 1'b0, 1'b0, 8'h00, 4'h0, 7'd0,
                                7'd3));
        plan.push_back(plan_row(OP_POP, 8'h00, 4'h0, 1'b1, 1'b1, 1'b0, 8'h00, 4'h0, 7'd0, 7'd2));
        plan.push_back(plan_row(OP_DISPATCH, 8'h00, 4'h0, 1'b0, 1'b0, 1'b0, 8'h00, 4'h0, 7'd0,
                                7'd0));
        plan.push_back(plan_row(OP_FINISHED, 8'h00, 4'h0, 1'b0, 1'b0, 1'b0, 8'h00, 4'h0, 7'd0,
                                7'd0));
        plan.push_back(plan_row(OP_PUSH, 8'h5a, 4'h0, 1'b0, 1'b0, 1'b0, 8'h00, 4'h0, 7'd0, 7'd0));
        plan.push_back(plan_row(OP_CANCEL_CHTY, 8'hff, 4'h0, 1'b0, 1'b0, 1'b0, 8'h00, 4'h0, 7'd0,
                                7'd0));
        plan.push_back(plan_row(OP_CANCEL_CHTY, 8'h01, 4'h1, 1'b0, 1'b0, 1'b0, 8'h00, 4'h0, 7'd0,
                                7'd0));
        plan.push_back(plan_row(OP_CANCEL_TY, 8'h00, 4'hf, 1'b0, 1'b0, 1'b0, 8'h00, 4'h0, 7'd0,
                                7'd0));
        plan.push_back(plan_row(OP_DISPATCH, 8'h00, 4'h0, 1'b0, 1'b0, 1'b0, 8'h00, 4'h0, 7'd0,
                                7'd0));
        plan.push_back(plan_row(OP_CANCEL_TY, 8'h00, 4'h0, 1'b0, 1'b0, 1'b0, 8'h00, 4'h0, 7'd0,
                                7'd0));
        plan.push_back(plan_row(OP_PUSH, 8'h81, 4'h9, 1'b0, 1'b0, 1'b0, 8'h00, 4'h0, 7'd0, 7'd0));
        plan.push_back(plan_row(OP_DISPATCH, 8'h00, 4'h0, 1'b0, 1'b0, 1'b0, 8'h00, 4'h0, 7'd0,
                                7'd0));
        plan.push_back(plan_row(OP_FLUSH, 8'h00, 4'h0, 1'b0, 1'b0, 1'b0, 8'h00, 4'h0, 7'd0, 7'd0));
        plan.push_back(plan_row(OP_POP, 8'h00, 4'h0, 1'b0, 1'b0, 1'b0, 8'h00, 4'h0, 7'd0, 7'd0));

        set_idle_mode(IDLE_NONE);
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan[i]) begin
            offer_request(plan[i].op, plan[i].ch, plan[i].ty, plan[i].typed, plan[i].want);
        end

        hold_off_wanted = 1'b1;
        repeat (QUEUE_DEPTH + 6) begin
            offer_request(OP_PUSH, pick_channel(), pick_type());
        end

        while (accepted_total < ITEM_TARGET) begin
            set_idle_mode(idle_mode_t'($urandom_range(3)));
            w = $urandom_range(9);
            if (w < 2) begin
                n = QUEUE_DEPTH - held + $urandom_range(1, 4);
                repeat (n) offer_request(OP_PUSH, pick_channel(), pick_type());
            end else if (w < 4) begin
                n = held + 2;
                repeat (n) begin
                    case ($urandom_range(2))
                        0:       op = OP_POP;
                        1:       op = OP_DISPATCH;
                        default: op = OP_FINISHED;
                    endcase
                    offer_request(op, pick_channel(), pick_type());
                end
            end else if (w < 5) begin
                repeat (3) begin
                    ch = pick_channel();
                    ty = pick_type();
                    if (held != 0 && $urandom_range(99) < 70) begin
                        src = head_slot + 6'($urandom_range(held - 1));
                        ch = slot_ch[src];
                        ty = slot_ty[src];
                    end
                    op = $urandom_range(1) ? OP_CANCEL_CHTY : OP_CANCEL_TY;
                    offer_request(op, ch, ty);
                end
            end else begin
                repeat (30) begin
                    n = $urandom_range(99);
                    if (n < 38)      op = OP_PUSH;
                    else if (n < 52) op = OP_POP;
                    else if (n < 66) op = OP_DISPATCH;
                    else if (n < 78) op = OP_FINISHED;
                    else if (n < 81) op = OP_FLUSH;
                    else if (n < 89) op = OP_CANCEL_CHTY;
                    else if (n < 97) op = OP_CANCEL_TY;
                    else             op = OP_UNUSED;
                    offer_request(op, pick_channel(), pick_type());
                end
            end
        end
        s_tvalid <= 1'b0;

        while (expected_replies.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
